FILE: design/olvd_pkg.sv
// Shared types and constants for the ordered list block.
package olvd_pkg;

   localparam int DATA_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_PREPEND = 2'd1,
      CMD_DELETE  = 2'd2,
      CMD_LIST    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [DATA_W-1:0]  item_value;
   } req_word_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  entry_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      last;
   } rsp_word_type;

endpackage

FILE: design/ordered_list_with_value_delete.sv
// Top level of the ordered list: control sequencer, ring pointers and result register.
//
// The list holds up to CAPACITY signed 32-bit entries in a ring memory with a front
// slot and an entry count. One request word is worked on at a time and the next is
// taken once the sequencer is back in idle. Append and prepend reply through the
// response state. Delete reads the memory one entry per cycle from the front until
// it finds the value, then moves each later entry one slot forward at one entry per
// cycle. List reads one entry per cycle and gives one result word per entry while
// results are taken every cycle. The single read port of the entry memory sets these
// figures. The result register lets a finished result wait while the next request is
// taken.
module ordered_list_with_value_delete
   import olvd_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = IDX_W + 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_LIST  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         occ_ff, occ_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   status_type               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [IDX_W-1:0]         rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic                     out_free;
   logic                     load;
   logic                     is_full;
   logic                     is_empty;
   logic                     at_last;
   logic                     shift_done;
   logic [EXT_W-1:0]         idx_ext;
   logic [EXT_W-1:0]         occ_ext;
   logic [EXT_W-1:0]         tail_sum;
   logic [IDX_W-1:0]         tail_slot;
   logic [IDX_W-1:0]         front_dec;
   logic [IDX_W-1:0]         slot_next;
   logic [IDX_W-1:0]         slot_next2;
   logic [COUNT_W-1:0]       count_out;

   function automatic logic [IDX_W-1:0] inc_slot(input logic [IDX_W-1:0] s);
      logic [IDX_W-1:0] r;
      if (s == IDX_W'(CAPACITY - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

   olvd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign idx_ext    = EXT_W'(idx_ff);
   assign occ_ext    = EXT_W'(occ_ff);
   assign is_full    = (occ_ext == EXT_W'(CAPACITY));
   assign is_empty   = (occ_ff == '0);
   assign at_last    = ((idx_ext + EXT_W'(1)) == occ_ext);
   assign shift_done = ((idx_ext + EXT_W'(2)) == occ_ext);
   assign tail_sum   = EXT_W'(front_ff) + occ_ext;
   assign tail_slot  = (tail_sum >= EXT_W'(CAPACITY)) ?
                       IDX_W'(tail_sum - EXT_W'(CAPACITY)) : IDX_W'(tail_sum);
   assign front_dec  = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign slot_next  = inc_slot(slot_ff);
   assign slot_next2 = inc_slot(slot_next);
   assign count_out  = COUNT_W'(occ_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      occ_in      = occ_ff;
      idx_in      = idx_ff;
      slot_in     = slot_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;
      wr_data     = value_ff;
      rd_addr     = front_ff;
      load        = 1'b0;
      rsp_word_in = rsp_word_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_word.item_value;
               idx_in   = '0;
               slot_in  = front_ff;
               case (req_word.cmd)
                  CMD_APPEND, CMD_PREPEND: begin
                     state_in = S_RESP;
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        wr_en     = 1'b1;
                        wr_data   = req_word.item_value;
                        occ_in    = occ_ff + 1'b1;
                        if (req_word.cmd == CMD_APPEND) begin
                           wr_addr = tail_slot;
                        end else begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_LIST;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr = slot_next;
            if ($signed(rd_data) == value_ff) begin
               if (at_last) begin
                  occ_in    = occ_ff - 1'b1;
                  status_in = ST_OK;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (at_last) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               idx_in  = idx_ff + 1'b1;
               slot_in = slot_next;
            end
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff;
            wr_data = rd_data;
            rd_addr = slot_next2;
            idx_in  = idx_ff + 1'b1;
            slot_in = slot_next;
            if (shift_done) begin
               occ_in    = occ_ff - 1'b1;
               status_in = ST_OK;
               state_in  = S_RESP;
            end
         end
         S_LIST: begin
            rd_addr = slot_ff;
            if (out_free) begin
               load                    = 1'b1;
               rsp_word_in.status      = ST_OK;
               rsp_word_in.entry_value = $signed(rd_data);
               rsp_word_in.entry_count = count_out;
               rsp_word_in.last        = at_last;
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  slot_in = slot_next;
                  rd_addr = slot_next;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               load                    = 1'b1;
               rsp_word_in.status      = status_ff;
               rsp_word_in.entry_value = '0;
               rsp_word_in.entry_count = count_out;
               rsp_word_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ext <= EXT_W'(CAPACITY))
      else $error("Entry count exceeds capacity.");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      EXT_W'(front_ff) < EXT_W'(CAPACITY))
      else $error("Front slot is outside the ring.");

   a_shift_ports: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (wr_addr != rd_addr))
      else $error("Shift writes the slot that it reads.");

   a_partial_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.last) |-> (rsp_word_ff.status == ST_OK))
      else $error("A non-final result word carries an error status.");

   a_idle_after_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("Single result word was not delivered to the result register.");
`endif

endmodule

FILE: design/olvd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module olvd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
